// File: sv/rk4_pkg.sv
package rk4_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] load_position;
    logic [31:0] load_velocity;
  } rk4_in_t;

  typedef struct packed {
    logic [47:0] time_now;
    logic [31:0] position_now;
    logic [31:0] velocity_now;
    logic        saturated;
  } rk4_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } rk4_state_e;

  localparam logic CFG_STEP_SIZE = 1'b0;
  localparam logic CFG_POS_OFFSET = 1'b1;
  localparam int MUL_BITS = 25;

endpackage

// File: sv/rk4_harmonic_oscillator_step_unit.sv
// A load transaction goes from ST_IDLE to ST_DONE and then raises its result valid; a step
// transaction runs eight dt products on the bit-serial multiplier (ST_MUL), one update
// (ST_UPD) after each, and a bit-serial divide by 3 (ST_DIV) for each of the two final
// sums. One transaction at a time; the next is accepted the cycle after the result leaves.
// Reset (asynchronous, active low): position = 1.0, velocity = 0, time = 0, dt = 0.01.
module rk4_harmonic_oscillator_step_unit
  import rk4_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rk4_in_t      in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rk4_out_t     out_data_o,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;
  // |floor((s*dt + 3*2^F) / 2^(F+1))| < 2^KSH; offset by 3*2^KSH to divide unsigned
  localparam int KSH = 58 - FRAC_BITS;
  localparam int DW  = KSH + 2;

  rk4_state_e state_q, state_d;
  logic [24:0] dt_q;
  logic signed [31:0] off_q;
  logic signed [31:0] x_q, v_q;
  logic [47:0] t_q;
  logic signed [31:0] px_q, pv_q;    // current stage point
  logic signed [35:0] sx_q, sv_q;    // weighted slope sums
  logic [2:0] idx_q, idx_d;          // product index: stage*2 + component
  logic sat_q;
  logic signed [31:0] nx_q;          // new position held between products
  rk4_out_t out_q;
  logic out_v_q;

  logic mul_start, mul_arm;
  logic signed [35:0] mul_a;
  logic signed [60:0] mul_p;
  logic [5:0] wait_q;

  // divide by 3, one quotient bit per cycle: dividend shifts out, quotient shifts in
  logic [DW-1:0] quo_q, quo_ld;
  logic [1:0] rem_q;
  logic [2:0] rem3;
  logic [5:0] dcnt_q;

  rk4_serial_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(dt_q), .p_o(mul_p)
  );

  // slope component for product idx: even -> x slope (=pv), odd -> v slope (=-px); idx 6, 7 -> sums sx, sv
  always_comb begin
    if (idx_q[2:1] == 2'd3) begin
      mul_a = idx_q[0] ? sv_q : sx_q;
    end else begin
      mul_a = idx_q[0] ? -36'(px_q) : 36'(pv_q);
    end
  end

  function automatic logic signed [63:0] rshift_round(input logic signed [63:0] n,
                                                      input int sh);
    logic signed [63:0] h;
    h = 64'sd1 <<< (sh - 1);
    return (n + h) >>> sh;
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [63:0] v,
                                              output logic f);
    f = 1'b0;
    if (v > SMAX) begin f = 1'b1; return 32'sh7fffffff; end
    if (v < SMIN) begin f = 1'b1; return 32'sh80000000; end
    return v[31:0];
  endfunction

  // final weighted sum: round(s*dt / (6*2^F)) = floor(floor((s*dt + 3*2^F) / 2^(F+1)) / 3);
  // the divide by 3 runs bit-serially in ST_DIV
  logic signed [63:0] num6, q6;
  logic signed [63:0] base, inc, sum;
  logic f1, f2;
  logic signed [31:0] cl, cl2;
  always_comb begin
    num6 = 64'(mul_p) + (64'sd3 <<< FRAC_BITS);
    quo_ld = DW'((num6 >>> (FRAC_BITS + 1)) + (64'sd3 <<< KSH));
    rem3 = {rem_q, quo_q[DW-1]};
    q6 = $signed(64'(quo_q)) - (64'sd1 <<< KSH);
    if (idx_q[2:1] == 2'd3) inc = q6;
    else if (idx_q[2:1] == 2'd2) inc = rshift_round(64'(mul_p), FRAC_BITS);
    else inc = rshift_round(64'(mul_p), FRAC_BITS + 1);
    base = idx_q[0] ? 64'(v_q) : 64'(x_q);
    sum = base + inc;
    cl = clip(sum, f1);
    cl2 = clip(64'(cl) + 64'(off_q), f2);
  end

  assign in_ready_o = (state_q == ST_IDLE) && !out_v_q;
  logic acc_in;
  assign acc_in = in_valid_i && in_ready_o;
  logic mul_ready;
  assign mul_ready = (wait_q == 6'd27);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc_in) state_d = in_data_i.func ? ST_DONE : ST_MUL;
      ST_MUL:  if (mul_ready) state_d = (idx_q[2:1] == 2'd3) ? ST_DIV : ST_UPD;
      ST_DIV:  if (dcnt_q == 6'(DW - 1)) state_d = ST_UPD;
      ST_UPD:  state_d = (idx_q == 3'd7) ? ST_DONE : ST_MUL;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // arm on entry to ST_MUL, start the product in its first cycle once operands settle
  always_comb begin
    mul_arm = (state_q == ST_IDLE && acc_in && !in_data_i.func) ||
              (state_q == ST_UPD && idx_q != 3'd7);
    mul_start = (state_q == ST_MUL) && (wait_q == 6'd0);
    idx_d = idx_q;
    if (state_q == ST_IDLE) idx_d = '0;
    else if (state_q == ST_UPD) idx_d = idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dt_q    <= 25'd167772;
      off_q   <= 32'sd839;
      x_q     <= 32'sd1 <<< FRAC_BITS;
      v_q     <= '0;
      t_q     <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
      wait_q  <= '0;
      sat_q   <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (mul_arm) wait_q <= '0;
      else if (!mul_ready) wait_q <= wait_q + 6'd1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STEP_SIZE:  dt_q  <= cfg_data_i[24:0];
          CFG_POS_OFFSET: off_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (acc_in) begin
        sat_q <= 1'b0;
        px_q  <= x_q;
        pv_q  <= v_q;
        sx_q  <= 36'(v_q);
        sv_q  <= -36'(x_q);
        if (in_data_i.func) begin
          x_q <= in_data_i.load_position;
          v_q <= in_data_i.load_velocity;
          t_q <= '0;
        end
      end
      // load the dividend as the product completes
      if (state_q == ST_MUL && mul_ready) begin
        quo_q  <= quo_ld;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      if (state_q == ST_DIV) begin
        quo_q  <= {quo_q[DW-2:0], (rem3 >= 3'd3)};
        rem_q  <= (rem3 >= 3'd3) ? 2'(rem3 - 3'd3) : rem3[1:0];
        dcnt_q <= dcnt_q + 6'd1;
      end
      if (state_q == ST_UPD) begin
        sat_q <= sat_q | f1 | ((idx_q == 3'd6) ? f2 : 1'b0);
        unique case (idx_q)
          3'd0, 3'd2, 3'd4: nx_q <= cl;
          3'd1, 3'd3: begin
            // stage point complete; next slope = (pv, -px), weight 2
            px_q <= nx_q; pv_q <= cl;
            sx_q <= sx_q + 36'(cl) + 36'(cl);
            sv_q <= sv_q - 36'(nx_q) - 36'(nx_q);
          end
          3'd5: begin
            px_q <= nx_q; pv_q <= cl;
            sx_q <= sx_q + 36'(cl);
            sv_q <= sv_q - 36'(nx_q);
          end
          3'd6: nx_q <= cl2;
          3'd7: begin
            x_q <= nx_q;
            v_q <= cl;
            t_q <= t_q + 48'(dt_q);
          end
          default: ;
        endcase
      end
      if (state_q == ST_DONE) out_v_q <= 1'b1;
    end
  end

  always_comb begin
    out_q.time_now     = t_q;
    out_q.position_now = x_q;
    out_q.velocity_now = v_q;
    out_q.saturated    = sat_q;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/rk4_serial_mul.sv
// Shift-add multiplier: a signed 36-bit multiplicand times an unsigned
// 25-bit multiplier, one multiplier bit per cycle.
module rk4_serial_mul
  import rk4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [35:0] a_i,
  input  logic        [24:0] b_i,
  output logic signed [60:0] p_o
);

  logic signed [60:0] acc_q, acc_d;
  logic signed [60:0] a_q, a_d;
  logic [24:0] b_q, b_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      a_d    = 61'(a_i);
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(MUL_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign p_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

endmodule

// File: verif/tb_rk4_harmonic_oscillator_step_unit.sv
`timescale 1ns / 100ps

module tb_rk4_harmonic_oscillator_step_unit;
  import rk4_pkg::*;

  localparam int FRAC = 24;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rk4_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rk4_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = CFG_STEP_SIZE;
  logic [31:0] cfg_data_i = '0;

  rk4_harmonic_oscillator_step_unit #(.FRAC_BITS(FRAC)) i_dut (.*);

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Oscillator state mirrored on the testbench side
  longint osc_dt, osc_offset, osc_pos, osc_vel;
  logic [47:0] osc_time;

  rk4_in_t pending_items[$];
  rk4_out_t expected_states[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;     // forced long receiver hold-off
  int rx_gap = 0, tx_gap = 0;
  logic in_ready_sampled = 1'b0;

  function automatic longint clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Round to nearest, ties toward plus infinity
  function automatic longint round_div(longint n, longint d);
    longint m;
    m = n + d / 2;
    if (m >= 0) return m / d;
    return -((-m + d - 1) / d);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 4);
  endfunction

  // Advance the mirrored oscillator by one transaction, return the new state
  function automatic rk4_out_t predict_oscillator(rk4_in_t it);
    rk4_out_t r;
    bit sat;
    longint half, full, kx1, kv1, kx2, kv2, kx3, kv3, kx4, kv4, px, pv, sx, sv;
    sat = 1'b0;
    half = 64'sd1 <<< (FRAC + 1);
    full = 64'sd1 <<< FRAC;
    if (it.func) begin
      osc_pos = longint'($signed(it.load_position));
      osc_vel = longint'($signed(it.load_velocity));
      osc_time = '0;
    end else begin
      kx1 = osc_vel;
      kv1 = -osc_pos;
      px = clip32(osc_pos + round_div(kx1 * osc_dt, half), sat);
      pv = clip32(osc_vel + round_div(kv1 * osc_dt, half), sat);
      kx2 = pv;
      kv2 = -px;
      px = clip32(osc_pos + round_div(kx2 * osc_dt, half), sat);
      pv = clip32(osc_vel + round_div(kv2 * osc_dt, half), sat);
      kx3 = pv;
      kv3 = -px;
      px = clip32(osc_pos + round_div(kx3 * osc_dt, full), sat);
      pv = clip32(osc_vel + round_div(kv3 * osc_dt, full), sat);
      kx4 = pv;
      kv4 = -px;
      sx = kx1 + 2 * kx2 + 2 * kx3 + kx4;
      sv = kv1 + 2 * kv2 + 2 * kv3 + kv4;
      px = clip32(osc_pos + round_div(sx * osc_dt, 6 * full), sat);
      pv = clip32(osc_vel + round_div(sv * osc_dt, 6 * full), sat);
      osc_pos = clip32(px + osc_offset, sat);
      osc_vel = pv;
      osc_time = osc_time + 48'(osc_dt);
    end
    r.time_now = osc_time;
    r.position_now = osc_pos[31:0];
    r.velocity_now = osc_vel[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // Driver: present the next pending transaction, hold it until accepted; also drive out_ready_i with gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_sampled) begin
        // hold
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        tx_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
      if (hold_rx) out_ready_i <= 1'b0;
      else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o) rx_gap <= gap_len();
      end
    end
  end

  // Acceptance seen at the last rising edge; predict on input transactions
  always @(posedge clk_i) begin
    in_ready_sampled <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) expected_states.push_back(predict_oscillator(in_data_i));
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    rk4_out_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_states.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction %h", $time, out_data_o);
        end else begin
          exp_r = expected_states.pop_front();
          if (exp_r !== out_data_o) begin
            error_count++;
            $display("%0t: expected time %h pos %h vel %h sat %b", $time, exp_r.time_now,
                     exp_r.position_now, exp_r.velocity_now, exp_r.saturated);
            $display("%0t: actual   time %h pos %h vel %h sat %b", $time,
                     out_data_o.time_now, out_data_o.position_now,
                     out_data_o.velocity_now, out_data_o.saturated);
          end
        end
      end
    end
  end

  task automatic add_load(logic [31:0] p, logic [31:0] v);
    rk4_in_t it;
    it.func = 1'b1;
    it.load_position = p;
    it.load_velocity = v;
    pending_items.push_back(it);
  endtask

  task automatic add_step(logic [31:0] noise);
    rk4_in_t it;
    it.func = 1'b0;
    it.load_position = noise;
    it.load_velocity = ~noise;
    pending_items.push_back(it);
  endtask

  // Wait on rising edges until nothing is queued, offered or in flight
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_states.size() != 0);
  endtask

  // Drain all traffic, then write a register while the block is idle
  task automatic write_reg(logic idx, logic [31:0] val);
    wait_idle();
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STEP_SIZE) osc_dt = longint'(val[24:0]);
    else osc_offset = longint'($signed(val));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 3))
          0: add_load($urandom(), $urandom());
          1: add_load(32'h7FFFFFFF, 32'h80000000);
          default: add_load($signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000,
                            $signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
        endcase
      end else begin
        add_step($urandom());
      end
    end
  endtask

  initial begin
    osc_dt = 167772;
    osc_offset = 839;
    osc_pos = 64'sd1 <<< FRAC;
    osc_vel = 0;
    osc_time = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, extremes, saturation in every direction
    add_step('0);
    add_step('1);
    add_load(32'h80000000, 32'h80000000);
    add_step('0);
    add_load(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_step('0);
    add_load(32'h7FFFFFFF, 32'h80000000);
    add_step('0);
    add_load('0, '0);
    add_step('0);
    add_load(32'hFFFFFFFF, 32'h00000001);
    add_step('0);

    // Fill the block while the receiver holds off
    hold_rx = 1'b1;
    random_phase(12);
    repeat (1500) @(posedge clk_i);
    hold_rx = 1'b0;

    random_phase(400);
    write_reg(CFG_STEP_SIZE, 32'd16777216);
    write_reg(CFG_POS_OFFSET, 32'h7FFFFFFF);
    add_load(32'h7FFF0000, 32'h7FFF0000);
    random_phase(300);
    write_reg(CFG_STEP_SIZE, 32'd0);
    write_reg(CFG_POS_OFFSET, 32'h80000000);
    random_phase(200);
    write_reg(CFG_STEP_SIZE, 32'h1FFFFFF);
    write_reg(CFG_POS_OFFSET, '0);
    random_phase(200);
    write_reg(CFG_STEP_SIZE, 32'd1);
    write_reg(CFG_POS_OFFSET, 32'hFFFFFFFF);
    random_phase(200);
    write_reg(CFG_STEP_SIZE, $urandom_range(0, 32'h1FFFFFF));
    write_reg(CFG_POS_OFFSET, $urandom());
    random_phase(380);

    wait_idle();
    repeat (500) @(posedge clk_i);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
